/* rtl/core/imre_pkg.sv */
// ----------------------------------------------------------------------------
// imre_pkg: shared types and constants for the I2C master retry engine
// Beat structs, phase codes, command codes and register indexes.
// ----------------------------------------------------------------------------
package imre_pkg;

	localparam int BufferDepth = 16;
	localparam int BufAw = $clog2(BufferDepth);

	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_CMD   = 3'd1;
	localparam logic [2:0] CMD_WR    = 3'd2;
	localparam logic [2:0] CMD_RD    = 3'd3;
	localparam logic [2:0] CMD_PRD   = 3'd4;
	localparam logic [2:0] CMD_PWR   = 3'd5;
	localparam logic [2:0] CMD_LOAD  = 3'd6;
	// op kinds after the write half of a read
	localparam logic [2:0] OP_RD_RX  = 3'd6;
	localparam logic [2:0] OP_PRD_RX = 3'd7;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_STA_A   = 4'd1;
	localparam logic [3:0] PH_STA_B   = 4'd2;
	localparam logic [3:0] PH_STA_C   = 4'd3;
	localparam logic [3:0] PH_TX      = 4'd4;
	localparam logic [3:0] PH_ACK_LO  = 4'd5;
	localparam logic [3:0] PH_ACK_HI  = 4'd6;
	localparam logic [3:0] PH_RX      = 4'd7;
	localparam logic [3:0] PH_MACK_LO = 4'd8;
	localparam logic [3:0] PH_MACK_HI = 4'd9;
	localparam logic [3:0] PH_STP_A   = 4'd10;
	localparam logic [3:0] PH_STP_B   = 4'd11;
	localparam logic [3:0] PH_STP_C   = 4'd12;
	localparam logic [3:0] PH_MID_A   = 4'd13;
	localparam logic [3:0] PH_MID_B   = 4'd14;
	localparam logic [3:0] PH_MID_C   = 4'd15;

	localparam logic [1:0] REG_HALF   = 2'd0;
	localparam logic [1:0] REG_WADDR  = 2'd1;
	localparam logic [1:0] REG_RADDR  = 2'd2;
	localparam logic [1:0] REG_MAXATT = 2'd3;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] reg_address;
		logic [7:0] data_byte;
		logic [4:0] length;
		logic       sda_in;
	} in_beat_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_pull_low;
		logic       busy_res;
		logic       done_res;
		logic       failed;
		logic       read_valid;
		logic [7:0] read_data;
		logic [3:0] read_index;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] half_period_ticks;
		logic [7:0] device_write_address;
		logic [7:0] device_read_address;
		logic [3:0] max_attempts;
	} cfg_t;

endpackage

/* rtl/core/imre_cfg.sv */
// ----------------------------------------------------------------------------
// imre_cfg: configuration register file
// Four registers written through a valid/ready port; always ready.
// ----------------------------------------------------------------------------
module imre_cfg import imre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	input  logic [1:0] wr_index_lo,
	input  logic       wr_in_range,
	input  logic [7:0] wr_data,
	output cfg_t       cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks    <= 8'd5;
			cfg_q.device_write_address <= 8'd224;
			cfg_q.device_read_address  <= 8'd225;
			cfg_q.max_attempts         <= 4'd4;
		end else if (wr_valid && wr_in_range) begin
			unique case (wr_index_lo)
				REG_HALF:   cfg_q.half_period_ticks    <= wr_data;
				REG_WADDR:  cfg_q.device_write_address <= wr_data;
				REG_RADDR:  cfg_q.device_read_address  <= wr_data;
				REG_MAXATT: cfg_q.max_attempts         <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

/* rtl/core/imre_seq.sv */
// ----------------------------------------------------------------------------
// imre_seq: bus pin sequencer
// One tick per step: phase machine, byte shifter, retry counting, buffer.
// ----------------------------------------------------------------------------
module imre_seq import imre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_beat_t  item,
	input  cfg_t      cfg,
	output out_beat_t res
);
	logic [3:0] phase_q;
	logic [7:0] tick_q;
	logic [3:0] bit_q;
	logic [7:0] shift_q;
	logic [3:0] att_q;
	logic [4:0] bidx_q;
	logic [2:0] kind_q;
	logic [7:0] taddr_q;
	logic [4:0] len_q;
	logic [7:0] cmdl_q;
	logic       ack_q;
	logic [7:0] wbuf [BufferDepth];

	logic [3:0] ph, ph_n;
	logic [7:0] tick_n;
	logic [3:0] bit_n;
	logic [7:0] shift_n;
	logic [3:0] att_n;
	logic [4:0] bidx_n;
	logic [2:0] kind_n;
	logic [7:0] taddr_n;
	logic [4:0] len_n;
	logic [7:0] cmdl_n;
	logic       ack_n;
	logic [7:0] hp;
	logic [3:0] maxa;
	logic       start, load_wr;
	logic [4:0] clen;
	logic [5:0] seg;
	logic [4:0] bi1;
	logic [7:0] nb;
	logic [4:0] wbi;
	logic [7:0] wbuf_rd;
	logic [7:0] tick_inc;
	out_beat_t  r;

	assign hp   = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
	assign maxa = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
	assign start   = (phase_q == PH_IDLE) && item.command >= CMD_CMD
		&& item.command <= CMD_PWR;
	assign load_wr = (phase_q == PH_IDLE) && item.command == CMD_LOAD
		&& ({1'b0, item.reg_address} < 9'(BufferDepth));
	assign clen = (item.length == 5'd0) ? 5'd1 :
		((item.length > 5'(BufferDepth)) ? 5'(BufferDepth) : item.length);

	always_ff @(posedge clk) begin
		if (step && load_wr) wbuf[item.reg_address[BufAw-1:0]] <= item.data_byte;
	end

	assign wbi = bi1 - 5'd2;
	assign wbuf_rd = wbuf[wbi[BufAw-1:0]];

	always_comb begin
		seg = 6'd1;
		case (kind_n)
			CMD_CMD: seg = 6'd2;
			CMD_WR:  seg = 6'd3;
			CMD_PWR: seg = 6'd2 + {1'b0, len_n};
			CMD_RD, CMD_PRD: seg = 6'd2;
			default: seg = 6'd1;
		endcase
	end

	always_comb begin
		nb = 8'd0;
		if (bi1 == 5'd0) nb = (kind_n >= OP_RD_RX) ? cfg.device_read_address
			: cfg.device_write_address;
		else if (kind_n == CMD_CMD) nb = cmdl_n;
		else if (bi1 == 5'd1) nb = taddr_n;
		else if (kind_n == CMD_WR) nb = cmdl_n;
		else if (kind_n == CMD_PWR && wbi < 5'(BufferDepth)) nb = wbuf_rd;
	end

	always_comb begin
		ph = phase_q; tick_n = tick_q; bit_n = bit_q; shift_n = shift_q;
		att_n = att_q; bidx_n = bidx_q; kind_n = kind_q; taddr_n = taddr_q;
		len_n = len_q; cmdl_n = cmdl_q; ack_n = ack_q;
		bi1 = bidx_q;
		r = '0;
		tick_inc = 8'd0;
		if (start) begin
			kind_n = item.command; taddr_n = item.reg_address;
			cmdl_n = item.data_byte;
			len_n = (item.command == CMD_PRD || item.command == CMD_PWR) ? clen : 5'd1;
			att_n = 4'd0; bidx_n = 5'd0; ack_n = 1'b0; bit_n = 4'd0;
			tick_n = 8'd0; shift_n = 8'd0; ph = PH_STA_A;
		end
		ph_n = ph;
		bi1 = bidx_n;
		if (ph == PH_IDLE) begin
			r.scl_level = 1'b1;
		end else begin
			r.busy_res = 1'b1;
			unique case (ph)
				PH_STA_A: begin r.scl_level = 1'b1; r.sda_pull_low = 1'b0; end
				PH_STA_B: begin r.scl_level = 1'b1; r.sda_pull_low = 1'b1; end
				PH_STA_C: begin r.scl_level = 1'b0; r.sda_pull_low = 1'b1; end
				PH_TX: begin
					r.scl_level = bit_n[0];
					r.sda_pull_low = ~shift_n[3'd7 - bit_n[3:1]];
				end
				PH_ACK_LO: begin r.scl_level = 1'b0; r.sda_pull_low = 1'b0; end
				PH_ACK_HI: begin r.scl_level = 1'b1; r.sda_pull_low = 1'b0; end
				PH_RX: begin r.scl_level = bit_n[0]; r.sda_pull_low = 1'b0; end
				PH_MACK_LO, PH_MACK_HI: begin
					r.scl_level = (ph == PH_MACK_HI);
					r.sda_pull_low = ({1'b0, bidx_n} + 6'd1) < {1'b0, len_n};
				end
				PH_STP_A, PH_MID_A: begin r.scl_level = 1'b0; r.sda_pull_low = 1'b1; end
				PH_STP_B, PH_MID_B: begin r.scl_level = 1'b1; r.sda_pull_low = 1'b1; end
				default: begin r.scl_level = 1'b1; r.sda_pull_low = 1'b0; end
			endcase
			tick_inc = tick_n + 8'd1;
			tick_n = tick_inc;
			if (tick_inc >= hp) begin
				tick_n = 8'd0;
				unique case (ph)
					PH_STA_A: ph_n = PH_STA_B;
					PH_STA_B: ph_n = PH_STA_C;
					PH_STA_C: begin
						shift_n = nb; bit_n = 4'd0; ph_n = PH_TX;
					end
					PH_TX: begin
						if (bit_n == 4'd15) ph_n = PH_ACK_LO;
						else bit_n = bit_n + 4'd1;
					end
					PH_ACK_LO: ph_n = PH_ACK_HI;
					PH_ACK_HI: begin
						ack_n = ~item.sda_in;
						if (item.sda_in) begin
							if ({1'b0, att_n} + 5'd1 < {1'b0, maxa}) begin
								att_n = att_n + 4'd1; bidx_n = 5'd0; ph_n = PH_STA_A;
							end else ph_n = PH_STP_A;
						end else begin
							bidx_n = bidx_n + 5'd1;
							bi1 = bidx_n;
							if ({1'b0, bidx_n} < seg) begin
								shift_n = nb; bit_n = 4'd0; ph_n = PH_TX;
							end else if (kind_n == CMD_RD || kind_n == CMD_PRD) begin
								kind_n = kind_n + 3'd3; ph_n = PH_MID_A;
							end else if (kind_n >= OP_RD_RX) begin
								bidx_n = 5'd0; bit_n = 4'd0; shift_n = 8'd0; ph_n = PH_RX;
							end else ph_n = PH_STP_A;
						end
					end
					PH_RX: begin
						if (bit_n[0]) shift_n = {shift_n[6:0], item.sda_in};
						if (bit_n == 4'd15) begin
							r.read_valid = 1'b1; r.read_data = shift_n;
							r.read_index = bidx_n[3:0]; ph_n = PH_MACK_LO;
						end else bit_n = bit_n + 4'd1;
					end
					PH_MACK_LO: ph_n = PH_MACK_HI;
					PH_MACK_HI: begin
						bidx_n = bidx_n + 5'd1;
						if (bidx_n < len_n) begin
							bit_n = 4'd0; shift_n = 8'd0; ph_n = PH_RX;
						end else ph_n = PH_STP_A;
					end
					PH_STP_A: ph_n = PH_STP_B;
					PH_STP_B: ph_n = PH_STP_C;
					PH_STP_C: begin
						r.busy_res = 1'b0; r.done_res = 1'b1; r.failed = ~ack_n;
						if (!ack_n && (kind_n == CMD_RD || kind_n == OP_RD_RX)) begin
							r.read_valid = 1'b1; r.read_data = 8'hFF; r.read_index = 4'd0;
						end
						ph_n = PH_IDLE;
					end
					PH_MID_A: ph_n = PH_MID_B;
					PH_MID_B: ph_n = PH_MID_C;
					PH_MID_C: begin
						att_n = 4'd0; bidx_n = 5'd0; ack_n = 1'b0; ph_n = PH_STA_A;
					end
					default: ph_n = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; tick_q <= '0; bit_q <= '0; shift_q <= '0;
			att_q <= '0; bidx_q <= '0; kind_q <= '0; taddr_q <= '0;
			len_q <= 5'd1; cmdl_q <= '0; ack_q <= 1'b0;
		end else if (step) begin
			phase_q <= ph_n; tick_q <= tick_n; bit_q <= bit_n; shift_q <= shift_n;
			att_q <= att_n; bidx_q <= bidx_n; kind_q <= kind_n; taddr_q <= taddr_n;
			len_q <= len_n; cmdl_q <= cmdl_n; ack_q <= ack_n;
		end
	end

	assign res = r;
endmodule

/* rtl/core/i2c_master_retry_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_retry_engine: I2C master with per-phase retry
// Runs one bus transaction at a time; each input beat is one time-base tick.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  in        in   in_valid / in_ready    in_beat_t  (command, address, data, sda)
//  out       out  out_valid / out_ready  out_beat_t (pins, status, read byte)
//  cfg       in   cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[7:0]
//
// One input beat per cycle, one result beat per input beat. The sequencer
// steps on every accepted tick; its result lands in a single output register.
// in_ready holds while the output register is empty or being drained, so the
// block sustains one beat per cycle with no bubbles. Reset (arst_n) returns
// the sequencer to idle and the registers to their defaults.
module i2c_master_retry_engine import imre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);
	cfg_t      cfg;
	out_beat_t res;
	out_beat_t res_q;
	logic      vld_q;
	logic      step;

	assign cfg_ready = 1'b1;
	assign in_ready  = !vld_q || out_ready;
	assign step      = in_valid && in_ready;

	imre_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .wr_valid(cfg_valid),
		.wr_index_lo(cfg_index[1:0]), .wr_in_range(cfg_index[7:2] == 6'd0),
		.wr_data(cfg_data), .cfg(cfg)
	);

	imre_seq u_seq (
		.clk(clk), .arst_n(arst_n), .step(step), .item(in_data),
		.cfg(cfg), .res(res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= res;
	end

	assign out_valid = vld_q;
	assign out_data  = res_q;
endmodule

/* rtl/core/imre_checker.sv */
// ----------------------------------------------------------------------------
// imre_checker: port-level checks for the retry engine
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module imre_checker import imre_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done with busy");
	a_fail_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.failed |-> out_data.done_res)
		else $error("failed without done");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted beat lost");
endmodule

bind i2c_master_retry_engine imre_checker u_imre_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the I2C master retry engine
// Drives bus ticks with random sda, predicts every result beat with an
// in-bench copy of the pin sequencer and checks each field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import imre_pkg::*;

	localparam int CycleLimit = 100000;
	localparam logic [2:0] CmdUnknown = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	i2c_master_retry_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle percentages for the two sides
	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int cycles = 0;
	int sent = 0;
	int stall_reqs = 0;
	int stall_seen = 0;
	int stall_left = 0;

	out_beat_t pin_results[$];

	// ---- predicted block state ----
	logic [7:0] m_half, m_waddr, m_raddr;
	logic [3:0] m_maxatt;
	logic [3:0] ph;
	logic [7:0] tick_cnt;
	logic [3:0] bit_cnt;
	logic [7:0] shreg;
	logic [3:0] attempts;
	logic [4:0] byte_idx;
	logic [2:0] kind;
	logic [7:0] reg_addr;
	logic [4:0] op_len;
	logic [7:0] cmd_byte;
	logic       acked;
	logic [7:0] wbuf [BufferDepth];

	task automatic pin_reset();
		m_half = 8'd5; m_waddr = 8'd224; m_raddr = 8'd225; m_maxatt = 4'd4;
		ph = PH_IDLE; tick_cnt = '0; bit_cnt = '0; shreg = '0; attempts = '0;
		byte_idx = '0; kind = '0; reg_addr = '0; op_len = 5'd1; cmd_byte = '0;
		acked = 1'b0;
	endtask

	// load the next byte to send: address, then command/register/data bytes
	task automatic load_tx();
		if (byte_idx == 0)
			shreg = (kind >= OP_RD_RX) ? m_raddr : m_waddr;
		else if (kind == CMD_CMD)
			shreg = cmd_byte;
		else if (byte_idx == 1)
			shreg = reg_addr;
		else if (kind == CMD_WR)
			shreg = cmd_byte;
		else if (kind == CMD_PWR && byte_idx - 2 < BufferDepth)
			shreg = wbuf[byte_idx - 2];
		else
			shreg = 8'h00;
		bit_cnt = '0;
		ph = PH_TX;
	endtask

	// one tick of the sequencer
	task automatic pin_step(input in_beat_t b, output out_beat_t r);
		int hp;
		int seg;
		int len;
		r = '0;
		hp = (m_half == 0) ? 1 : m_half;
		if (ph == PH_IDLE) begin
			if (b.command == CMD_LOAD) begin
				if (b.reg_address < BufferDepth)
					wbuf[b.reg_address[BufAw-1:0]] = b.data_byte;
			end else if (b.command >= CMD_CMD && b.command <= CMD_PWR) begin
				kind = b.command;
				reg_addr = b.reg_address;
				cmd_byte = b.data_byte;
				len = b.length;
				if (b.command == CMD_PRD || b.command == CMD_PWR) begin
					if (len < 1) len = 1;
					if (len > BufferDepth) len = BufferDepth;
					op_len = len[4:0];
				end else begin
					op_len = 5'd1;
				end
				attempts = '0; byte_idx = '0; acked = 1'b0;
				bit_cnt = '0; tick_cnt = '0; shreg = '0;
				ph = PH_STA_A;
			end
		end
		if (ph == PH_IDLE) begin
			r.scl_level = 1'b1;
			return;
		end
		r.busy_res = 1'b1;
		// pins reflect the slot before advancing
		case (ph)
			PH_STA_A: begin r.scl_level = 1; r.sda_pull_low = 0; end
			PH_STA_B: begin r.scl_level = 1; r.sda_pull_low = 1; end
			PH_STA_C: begin r.scl_level = 0; r.sda_pull_low = 1; end
			PH_TX: begin
				r.scl_level = bit_cnt[0];
				r.sda_pull_low = ~shreg[7 - bit_cnt[3:1]];
			end
			PH_ACK_LO: begin r.scl_level = 0; r.sda_pull_low = 0; end
			PH_ACK_HI: begin r.scl_level = 1; r.sda_pull_low = 0; end
			PH_RX: begin r.scl_level = bit_cnt[0]; r.sda_pull_low = 0; end
			PH_MACK_LO, PH_MACK_HI: begin
				r.scl_level = (ph == PH_MACK_HI);
				r.sda_pull_low = (int'(byte_idx) + 1 < int'(op_len));
			end
			PH_STP_A, PH_MID_A: begin r.scl_level = 0; r.sda_pull_low = 1; end
			PH_STP_B, PH_MID_B: begin r.scl_level = 1; r.sda_pull_low = 1; end
			default: begin r.scl_level = 1; r.sda_pull_low = 0; end
		endcase
		tick_cnt = tick_cnt + 8'd1;
		if (tick_cnt < hp)
			return;
		tick_cnt = '0;
		case (ph)
			PH_STA_A: ph = PH_STA_B;
			PH_STA_B: ph = PH_STA_C;
			PH_STA_C: load_tx();
			PH_TX: if (bit_cnt == 4'd15) ph = PH_ACK_LO; else bit_cnt++;
			PH_ACK_LO: ph = PH_ACK_HI;
			PH_ACK_HI: begin
				acked = (b.sda_in == 1'b0);
				if (!acked) begin
					// no ack: repeated start until the attempt budget runs out
					if (int'(attempts) + 1 < int'(m_maxatt)) begin
						attempts++;
						byte_idx = '0;
						ph = PH_STA_A;
					end else begin
						ph = PH_STP_A;
					end
				end else begin
					byte_idx++;
					case (kind)
						CMD_CMD: seg = 2;
						CMD_WR: seg = 3;
						CMD_PWR: seg = 2 + op_len;
						CMD_RD, CMD_PRD: seg = 2;
						default: seg = 1;
					endcase
					if (byte_idx < seg) begin
						load_tx();
					end else if (kind == CMD_RD || kind == CMD_PRD) begin
						kind = kind + 3'd3;
						ph = PH_MID_A;
					end else if (kind >= OP_RD_RX) begin
						byte_idx = '0; bit_cnt = '0; shreg = '0;
						ph = PH_RX;
					end else begin
						ph = PH_STP_A;
					end
				end
			end
			PH_RX: begin
				if (bit_cnt[0])
					shreg = {shreg[6:0], b.sda_in};
				if (bit_cnt == 4'd15) begin
					r.read_valid = 1'b1;
					r.read_data = shreg;
					r.read_index = byte_idx[3:0];
					ph = PH_MACK_LO;
				end else begin
					bit_cnt++;
				end
			end
			PH_MACK_LO: ph = PH_MACK_HI;
			PH_MACK_HI: begin
				byte_idx++;
				if (byte_idx < op_len) begin
					bit_cnt = '0; shreg = '0;
					ph = PH_RX;
				end else begin
					ph = PH_STP_A;
				end
			end
			PH_STP_A: ph = PH_STP_B;
			PH_STP_B: ph = PH_STP_C;
			PH_STP_C: begin
				r.busy_res = 1'b0;
				r.done_res = 1'b1;
				r.failed = !acked;
				// failed single read hands back 0xFF
				if (!acked && (kind == CMD_RD || kind == OP_RD_RX)) begin
					r.read_valid = 1'b1;
					r.read_data = 8'hFF;
				end
				ph = PH_IDLE;
			end
			PH_MID_A: ph = PH_MID_B;
			PH_MID_B: ph = PH_MID_C;
			PH_MID_C: begin
				attempts = '0; byte_idx = '0; acked = 1'b0;
				ph = PH_STA_A;
			end
			default: ph = PH_IDLE;
		endcase
	endtask

	// ---- drivers ----
	task automatic send_beat(input in_beat_t b);
		out_beat_t r;
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		sent++;
		pin_step(b, r);
		pin_results.push_back(r);
	endtask

	// idle tick with random don't-care fields; sda acks with the given odds
	task automatic send_tick(input int ack_pct);
		in_beat_t b;
		b.command = 3'($urandom_range(0, 7));
		b.reg_address = 8'($urandom);
		b.data_byte = 8'($urandom);
		b.length = 5'($urandom);
		b.sda_in = ($urandom_range(99) < ack_pct) ? 1'b0 : 1'b1;
		if (ph == PH_IDLE)
			b.command = CMD_TICK;
		send_beat(b);
	endtask

	task automatic run_txn(input logic [2:0] cmd, input logic [7:0] ra,
			input logic [7:0] db, input logic [4:0] len, input int ack_pct);
		in_beat_t b;
		b.command = cmd;
		b.reg_address = ra;
		b.data_byte = db;
		b.length = len;
		b.sda_in = 1'($urandom);
		send_beat(b);
		while (ph != PH_IDLE)
			send_tick(ack_pct);
	endtask

	// registers change only with the block idle and drained
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		in_valid <= 1'b0;
		while (pin_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= 8'(idx);
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HALF: m_half = val;
			REG_WADDR: m_waddr = val;
			REG_RADDR: m_raddr = val;
			default: m_maxatt = val[3:0];
		endcase
		@(posedge clk);
	endtask

	// ---- receiver ----
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (stall_reqs != stall_seen) begin
			stall_seen <= stall_reqs;
			stall_left <= 400;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pin_results.size() == 0) begin
				report("unexpected beat", int'(out_data), 0);
			end else begin
				want = pin_results.pop_front();
				if (out_data.scl_level !== want.scl_level)
					report("scl_level", out_data.scl_level, want.scl_level);
				if (out_data.sda_pull_low !== want.sda_pull_low)
					report("sda_pull_low", out_data.sda_pull_low, want.sda_pull_low);
				if (out_data.busy_res !== want.busy_res)
					report("busy_res", out_data.busy_res, want.busy_res);
				if (out_data.done_res !== want.done_res)
					report("done_res", out_data.done_res, want.done_res);
				if (out_data.failed !== want.failed)
					report("failed", out_data.failed, want.failed);
				if (out_data.read_valid !== want.read_valid)
					report("read_valid", out_data.read_valid, want.read_valid);
				if (out_data.read_data !== want.read_data)
					report("read_data", out_data.read_data, want.read_data);
				if (out_data.read_index !== want.read_index)
					report("read_index", out_data.read_index, want.read_index);
			end
		end
	end

	// ---- tests ----
	task automatic test_buffer_loads();
		in_beat_t b;
		for (int i = 0; i < BufferDepth; i++)
			run_txn(CMD_LOAD, 8'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
				5'd0, 100);
		// out of range load, unknown code
		run_txn(CMD_LOAD, 8'hFF, 8'hA5, 5'd31, 100);
		b = '0;
		b.command = CmdUnknown;
		b.reg_address = 8'h3C;
		send_beat(b);
	endtask

	task automatic test_directed_ops();
		run_txn(CMD_CMD, 8'h00, 8'hFF, 5'd0, 100);    // default timing
		write_reg(REG_HALF, 8'd1);
		write_reg(REG_WADDR, 8'hFF);
		write_reg(REG_RADDR, 8'h00);
		write_reg(REG_MAXATT, 4'd2);
		run_txn(CMD_WR, 8'hFF, 8'h00, 5'd31, 100);
		run_txn(CMD_RD, 8'h12, 8'h00, 5'd0, 100);
		run_txn(CMD_RD, 8'h12, 8'h00, 5'd0, 0);       // read nacked throughout
		run_txn(CMD_PWR, 8'h80, 8'h00, 5'd17, 100);   // oversize length
		run_txn(CMD_WR, 8'h01, 8'h02, 5'd1, 0);       // retries then fail
		write_reg(REG_MAXATT, 4'd0);                  // no retry
		write_reg(REG_HALF, 8'd0);                    // acts as one
		run_txn(CMD_PRD, 8'h05, 8'h00, 5'd0, 85);     // zero length
		write_reg(REG_HALF, 8'd4);                    // slower bus, one attempt
		write_reg(REG_MAXATT, 4'd1);
		write_reg(REG_WADDR, 8'h00);
		write_reg(REG_RADDR, 8'hFF);
		run_txn(CMD_CMD, 8'h00, 8'h81, 5'd0, 0);
	endtask

	task automatic test_random(input int items);
		int goal;
		int pick;
		int ack;
		goal = sent + items;
		write_reg(REG_HALF, 8'($urandom_range(0, 2)));
		write_reg(REG_WADDR, 8'($urandom));
		write_reg(REG_RADDR, 8'($urandom));
		write_reg(REG_MAXATT, 8'($urandom_range(0, 3)));
		while (sent < goal) begin
			pick = $urandom_range(0, 9);
			case ($urandom_range(0, 3))
				0: ack = 100;
				1: ack = 92;
				2: ack = 65;
				default: ack = 10;
			endcase
			if (pick < 3) begin
				run_txn(CMD_LOAD, 8'($urandom_range(0, 31)), 8'($urandom), 5'($urandom), 100);
			end else if (pick == 3) begin
				run_txn($urandom_range(0, 1) ? CMD_TICK : CmdUnknown, 8'($urandom),
					8'($urandom), 5'($urandom), 100);
			end else begin
				run_txn(3'($urandom_range(1, 5)), 8'($urandom), 8'($urandom),
					5'($urandom_range(0, 5)), ack);
			end
		end
	endtask

	task automatic test_backpressure();
		stall_reqs++;
		run_txn(CMD_PRD, 8'($urandom), 8'h00, 5'd4, 80);
	endtask

	initial begin
		pin_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 29; recv_idle = 75;
		test_buffer_loads();
		test_directed_ops();
		send_idle = 75; recv_idle = 29;
		test_random(100);
		send_idle = 0; recv_idle = 0;
		test_random(100);
		test_backpressure();
		test_random(100);
		in_valid <= 1'b0;
		while (pin_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
